// ===== hw/rtl/char_lcd_4bit_writer_top_assert.svh =====
// assertion macros shared by the character lcd writer modules
// no dependencies; included by the files that check their own logic
`ifndef CHAR_LCD_4BIT_WRITER_TOP_ASSERT_SVH
`define CHAR_LCD_4BIT_WRITER_TOP_ASSERT_SVH

// same-cycle implication
`define CLCD_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("clcd check failed");

// next-cycle implication
`define CLCD_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("clcd check failed");

`endif

// ===== hw/rtl/clcd_pkg.sv =====
// shared types, codes and constants of the character lcd writer
// no dependencies
package clcd_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int CSR_DATA_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH = 3;

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [2:0] mode_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;
   typedef logic [3:0] init_idx_type;

   // request codes
   localparam mode_type MODE_TICK   = 3'd0;
   localparam mode_type MODE_CMD    = 3'd1;
   localparam mode_type MODE_CHAR   = 3'd2;
   localparam mode_type MODE_CURSOR = 3'd3;
   localparam mode_type MODE_INIT   = 3'd4;

   // register indexes
   localparam csr_index_type CSR_ENABLE_TICKS = 3'd0;
   localparam csr_index_type CSR_SHORT_WAIT   = 3'd1;
   localparam csr_index_type CSR_LONG_WAIT    = 3'd2;
   localparam csr_index_type CSR_POWER_UP     = 3'd3;
   localparam csr_index_type CSR_INIT_GAP     = 3'd4;

   // register reset values
   localparam logic [7:0]  RST_ENABLE_TICKS = 8'd1;
   localparam logic [15:0] RST_SHORT_WAIT   = 16'd40;
   localparam logic [15:0] RST_LONG_WAIT    = 16'd2000;
   localparam logic [15:0] RST_POWER_UP     = 16'd15000;
   localparam logic [15:0] RST_INIT_GAP     = 16'd5000;

   // commands that need the long wait
   localparam logic [7:0] CMD_CLEAR = 8'h01;
   localparam logic [7:0] CMD_HOME  = 8'h02;

   localparam logic [3:0] WAKE_NIBBLE  = 4'h3;
   localparam logic [3:0] FUNC_NIBBLE  = 4'h2;
   localparam init_idx_type WAKE_COUNT = 4'd3;
   localparam init_idx_type INIT_CMD_FIRST = 4'd4;
   localparam int INIT_CMD_COUNT = 6;
   localparam init_idx_type INIT_CMD_END = INIT_CMD_FIRST + 4'(INIT_CMD_COUNT);

   localparam logic [31:0] COUNT_MAX32 = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

   typedef struct packed {
      logic [7:0]  enable_ticks;
      logic [15:0] short_wait_ticks;
      logic [15:0] long_wait_ticks;
      logic [15:0] power_up_ticks;
      logic [15:0] init_gap_ticks;
   } cfg_type;

   typedef struct packed {
      mode_type   mode;
      logic [7:0] data_byte;
      logic       row;
      logic [3:0] column;
   } req_item_type;

   typedef struct packed {
      logic       enable_pin;
      logic       select_pin;
      logic [3:0] bus_nibble;
      logic       busy_res;
      logic       accepted;
   } rsp_item_type;

   // power-up command list
   function automatic logic [7:0] init_cmd(input logic [2:0] pos);
      logic [7:0] cmd;
      case (pos)
         3'd0:    cmd = 8'h28;
         3'd1:    cmd = 8'h08;
         3'd2:    cmd = 8'h01;
         3'd3:    cmd = 8'h06;
         3'd4:    cmd = 8'h0C;
         3'd5:    cmd = 8'h02;
         default: cmd = 8'h02;
      endcase
      return cmd;
   endfunction

   // zero counts as one, too-large counts saturate
   function automatic count_type load_count(input logic [15:0] ticks);
      logic [31:0] wide;
      count_type   cnt;
      wide = 32'(ticks);
      if (ticks == 16'd0) begin
         cnt = count_type'(1);
      end else if (wide > COUNT_MAX32) begin
         cnt = '1;
      end else begin
         cnt = count_type'(wide);
      end
      return cnt;
   endfunction

endpackage

// ===== hw/rtl/clcd_ifs.sv =====
// valid/ready channel interfaces of the character lcd writer
// depends on clcd_pkg
interface clcd_req_if import clcd_pkg::*; ();
   logic       valid;
   logic       ready;
   mode_type   mode;
   logic [7:0] data_byte;
   logic       row;
   logic [3:0] column;

   modport source (output valid, output mode, output data_byte, output row,
                   output column, input ready);
   modport sink (input valid, input mode, input data_byte, input row,
                 input column, output ready);
endinterface

interface clcd_rsp_if ();
   logic       valid;
   logic       ready;
   logic       enable_pin;
   logic       select_pin;
   logic [3:0] bus_nibble;
   logic       busy_res;
   logic       accepted;

   modport source (output valid, output enable_pin, output select_pin,
                   output bus_nibble, output busy_res, output accepted, input ready);
   modport sink (input valid, input enable_pin, input select_pin,
                 input bus_nibble, input busy_res, input accepted, output ready);
endinterface

// ===== hw/rtl/clcd_ctrl.sv =====
// sequencer of the lcd bus: phase, tick counter, held byte and pin levels
// depends on clcd_pkg and the assertion macro header
`include "char_lcd_4bit_writer_top_assert.svh"

module clcd_ctrl import clcd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         step_en,
   input  req_item_type req,
   input  cfg_type      cfg,
   output rsp_item_type rsp_next
);

   typedef enum logic [3:0] {
      PH_IDLE       = 4'd0,
      PH_POWER      = 4'd1,
      PH_WAKE_SETUP = 4'd2,
      PH_WAKE_EN    = 4'd3,
      PH_WAKE_GAP   = 4'd4,
      PH_SETUP_HI   = 4'd5,
      PH_EN_HI      = 4'd6,
      PH_SETUP_LO   = 4'd7,
      PH_EN_LO      = 4'd8,
      PH_SHORT      = 4'd9,
      PH_LONG       = 4'd10
   } phase_type;

   phase_type    phase_ff, phase_in;
   count_type    count_ff, count_in, count_dec;
   logic [7:0]   byte_ff, byte_in;
   logic         sel_ff, sel_in;
   init_idx_type idx_ff, idx_in, idx_nxt;
   logic         long_ff, long_in;
   logic         en_ff, en_in;
   logic [3:0]   nib_ff, nib_in;
   logic         acc;
   logic         do_finish;
   logic         st_go;
   logic [7:0]   st_byte;
   logic         st_sel;

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      byte_in   = byte_ff;
      sel_in    = sel_ff;
      idx_in    = idx_ff;
      long_in   = long_ff;
      en_in     = en_ff;
      nib_in    = nib_ff;
      acc       = 1'b0;
      do_finish = 1'b0;
      st_go     = 1'b0;
      st_byte   = 8'h00;
      st_sel    = 1'b0;
      count_dec = count_ff;
      idx_nxt   = idx_ff + 4'd1;

      case (req.mode)
         MODE_TICK: begin
            if (phase_ff != PH_IDLE) begin
               if (count_ff != '0) begin
                  count_dec = count_ff - count_type'(1);
               end
               count_in = count_dec;
               if (count_dec == '0) begin
                  case (phase_ff)
                     PH_POWER: begin
                        idx_in   = '0;
                        nib_in   = WAKE_NIBBLE;
                        phase_in = PH_WAKE_SETUP;
                        count_in = load_count(16'(cfg.enable_ticks));
                     end
                     PH_WAKE_SETUP: begin
                        en_in    = 1'b1;
                        phase_in = PH_WAKE_EN;
                        count_in = load_count(16'(cfg.enable_ticks));
                     end
                     PH_WAKE_EN: begin
                        en_in = 1'b0;
                        if (idx_ff < WAKE_COUNT) begin
                           phase_in = PH_WAKE_GAP;
                           count_in = load_count(cfg.init_gap_ticks);
                        end else begin
                           idx_in  = INIT_CMD_FIRST;
                           st_go   = 1'b1;
                           st_byte = init_cmd(3'd0);
                        end
                     end
                     PH_WAKE_GAP: begin
                        idx_in   = idx_nxt;
                        nib_in   = (idx_nxt < WAKE_COUNT) ? WAKE_NIBBLE : FUNC_NIBBLE;
                        phase_in = PH_WAKE_SETUP;
                        count_in = load_count(16'(cfg.enable_ticks));
                     end
                     PH_SETUP_HI: begin
                        en_in    = 1'b1;
                        phase_in = PH_EN_HI;
                        count_in = load_count(16'(cfg.enable_ticks));
                     end
                     PH_EN_HI: begin
                        en_in    = 1'b0;
                        nib_in   = byte_ff[3:0];
                        phase_in = PH_SETUP_LO;
                        count_in = load_count(16'(cfg.enable_ticks));
                     end
                     PH_SETUP_LO: begin
                        en_in    = 1'b1;
                        phase_in = PH_EN_LO;
                        count_in = load_count(16'(cfg.enable_ticks));
                     end
                     PH_EN_LO: begin
                        en_in    = 1'b0;
                        phase_in = PH_SHORT;
                        count_in = load_count(cfg.short_wait_ticks);
                     end
                     PH_SHORT: begin
                        if (long_ff) begin
                           phase_in = PH_LONG;
                           count_in = load_count(cfg.long_wait_ticks);
                        end else begin
                           do_finish = 1'b1;
                        end
                     end
                     PH_LONG: begin
                        do_finish = 1'b1;
                     end
                     default: begin
                        phase_in = PH_IDLE;
                        count_in = '0;
                     end
                  endcase
               end
            end
         end
         MODE_CMD, MODE_CHAR, MODE_CURSOR, MODE_INIT: begin
            if (phase_ff == PH_IDLE) begin
               acc    = 1'b1;
               idx_in = '0;
               case (req.mode)
                  MODE_CMD: begin
                     st_go   = 1'b1;
                     st_byte = req.data_byte;
                  end
                  MODE_CHAR: begin
                     st_go   = 1'b1;
                     st_byte = req.data_byte;
                     st_sel  = 1'b1;
                  end
                  MODE_CURSOR: begin
                     // set ddram address: row picks 0x00 or 0x40
                     st_go   = 1'b1;
                     st_byte = {1'b1, req.row, 2'b00, req.column};
                  end
                  default: begin
                     sel_in   = 1'b0;
                     en_in    = 1'b0;
                     long_in  = 1'b0;
                     phase_in = PH_POWER;
                     count_in = load_count(cfg.power_up_ticks);
                  end
               endcase
            end
         end
         default: begin
         end
      endcase

      // end of a byte: next init command or back to idle
      if (do_finish) begin
         if (idx_ff >= INIT_CMD_FIRST && idx_nxt < INIT_CMD_END) begin
            idx_in  = idx_nxt;
            st_go   = 1'b1;
            st_byte = init_cmd(3'(idx_nxt - INIT_CMD_FIRST));
         end else begin
            idx_in   = '0;
            phase_in = PH_IDLE;
            count_in = '0;
         end
      end

      if (st_go) begin
         byte_in  = st_byte;
         sel_in   = st_sel;
         long_in  = !st_sel && (st_byte == CMD_CLEAR || st_byte == CMD_HOME);
         en_in    = 1'b0;
         nib_in   = st_byte[7:4];
         phase_in = PH_SETUP_HI;
         count_in = load_count(16'(cfg.enable_ticks));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         byte_ff  <= 8'h00;
         sel_ff   <= 1'b0;
         idx_ff   <= '0;
         long_ff  <= 1'b0;
         en_ff    <= 1'b0;
         nib_ff   <= 4'h0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         byte_ff  <= byte_in;
         sel_ff   <= sel_in;
         idx_ff   <= idx_in;
         long_ff  <= long_in;
         en_ff    <= en_in;
         nib_ff   <= nib_in;
      end
   end

   always_comb begin
      rsp_next.enable_pin = en_in;
      rsp_next.select_pin = sel_in;
      rsp_next.bus_nibble = nib_in;
      rsp_next.busy_res   = (phase_in != PH_IDLE);
      rsp_next.accepted   = acc;
   end

   `CLCD_ASSERT_NOW(a_idle_count_zero, clock, reset, phase_ff == PH_IDLE, count_ff == '0)
   `CLCD_ASSERT_NOW(a_busy_count_live, clock, reset, phase_ff != PH_IDLE, count_ff != '0)
   `CLCD_ASSERT_NOW(a_init_idx_range, clock, reset, 1'b1, idx_ff < INIT_CMD_END)

endmodule

// ===== hw/rtl/clcd_out_buf.sv =====
// two-entry result buffer: output register plus skid register
// depends on clcd_pkg and the assertion macro header
`include "char_lcd_4bit_writer_top_assert.svh"

module clcd_out_buf import clcd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  rsp_item_type in_item,
   output logic         in_ready,
   output logic         out_valid,
   output rsp_item_type out_item,
   input  logic         out_ready
);

   logic         main_valid_ff, main_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type main_ff, main_in;
   rsp_item_type skid_ff, skid_in;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_item  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = in_item;
            main_valid_in = in_valid;
         end
      end else if (in_valid) begin
         // output stalled: park the transfer in the skid register
         skid_in       = in_item;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   `CLCD_ASSERT_NOW(a_skid_needs_main, clock, reset, skid_valid_ff, main_valid_ff)
   `CLCD_ASSERT_NEXT(a_stall_fills_skid, clock, reset,
                     main_valid_ff && !out_ready && in_valid, skid_valid_ff)
   `CLCD_ASSERT_NEXT(a_skid_drains, clock, reset,
                     skid_valid_ff && out_ready, main_valid_ff && !skid_valid_ff)

endmodule

// ===== hw/rtl/char_lcd_4bit_writer_top.sv =====
// each input transfer's result is registered in the buffer's main or skid register
// throughput: one tick or request per cycle while the result buffer has room
// a two-entry result buffer keeps input transfers flowing by parking one in its skid
// reset: synchronous, active high; clears the sequencer to idle with pins low and
// loads the default tick counts into the configuration registers
module char_lcd_4bit_writer_top import clcd_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   clcd_req_if.sink                   req,
   clcd_rsp_if.source                 rsp,
   input  logic                       csr_write_enable,
   input  csr_index_type              csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   cfg_type      cfg_ff;
   req_item_type req_item;
   rsp_item_type rsp_next;
   rsp_item_type rsp_item;
   logic         req_accept;
   logic         buf_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable_ticks     <= RST_ENABLE_TICKS;
         cfg_ff.short_wait_ticks <= RST_SHORT_WAIT;
         cfg_ff.long_wait_ticks  <= RST_LONG_WAIT;
         cfg_ff.power_up_ticks   <= RST_POWER_UP;
         cfg_ff.init_gap_ticks   <= RST_INIT_GAP;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ENABLE_TICKS: cfg_ff.enable_ticks     <= csr_write_data[7:0];
            CSR_SHORT_WAIT:   cfg_ff.short_wait_ticks <= csr_write_data;
            CSR_LONG_WAIT:    cfg_ff.long_wait_ticks  <= csr_write_data;
            CSR_POWER_UP:     cfg_ff.power_up_ticks   <= csr_write_data;
            CSR_INIT_GAP:     cfg_ff.init_gap_ticks   <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   assign req.ready  = buf_ready;
   assign req_accept = req.valid && buf_ready;

   always_comb begin
      req_item.mode      = req.mode;
      req_item.data_byte = req.data_byte;
      req_item.row       = req.row;
      req_item.column    = req.column;
   end

   clcd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .step_en  (req_accept),
      .req      (req_item),
      .cfg      (cfg_ff),
      .rsp_next (rsp_next)
   );

   clcd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .in_item   (rsp_next),
      .in_ready  (buf_ready),
      .out_valid (rsp.valid),
      .out_item  (rsp_item),
      .out_ready (rsp.ready)
   );

   assign rsp.enable_pin = rsp_item.enable_pin;
   assign rsp.select_pin = rsp_item.select_pin;
   assign rsp.bus_nibble = rsp_item.bus_nibble;
   assign rsp.busy_res   = rsp_item.busy_res;
   assign rsp.accepted   = rsp_item.accepted;

endmodule
